FILE: rtl/gaussian_noise_generator_assert.svh
// Assertion macros shared by the gaussian noise generator sources.
`ifndef GAUSSIAN_NOISE_GENERATOR_ASSERT_SVH
`define GAUSSIAN_NOISE_GENERATOR_ASSERT_SVH
// Checks a property on every rising edge outside reset.
`define GNG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks an implication whose consequence is checked in the cycle after the cause.
`define GNG_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cause) |=> (effect)) \
    else $error(msg);
`endif

FILE: rtl/gng_pkg.sv
// Shared types, constants and tables of the gaussian noise generator.
`timescale 1ns / 1ps
package gng_pkg;
  localparam int unsigned FracBits   = 12;
  localparam logic [31:0] LcgMul     = 32'd1664525;
  localparam logic [31:0] LcgAdd     = 32'd1013904223;
  localparam logic [28:0] TwoLn2Q28  = 29'd372130559;
  localparam logic [39:0] R2AtZero   = 40'd138453387389;
  localparam logic [33:0] CordicK    = 34'd652032874;
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned LogSteps    = 30;
  localparam int unsigned SqrtSteps   = 20;
  localparam int unsigned QDepth      = 2;
  localparam int unsigned QPtrW       = 1;

  typedef struct packed {
    logic        valid;
    logic [15:0] a;
    logic [15:0] b;
  } q_wr_t;

  typedef struct packed {
    logic        full;
    logic        empty;
    logic [15:0] a;
    logic [15:0] b;
  } q_rd_t;

  // Position of the leading one of a nonzero 16-bit value.
  function automatic logic [3:0] lead_pos(input logic [15:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) n = 4'(i);
    end
    return n;
  endfunction

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction
endpackage

FILE: rtl/gaussian_noise_generator.sv
// Top level of the gaussian noise generator.
`timescale 1ns / 1ps
// Usage:
// Each transaction on the slave stream requests one normal deviate; bit 0 of
// s_axis_tdata is the restart flag, which reloads the LCG from the seed first.
// The master stream returns one signed sample per request in Q3.12.
// The seed register is written through cfg_valid/cfg_data and is always
// ready; write it only while the block is idle. It takes effect at restart.
// From request to sample, the front end runs two LCG multiplies, then the
// back end runs 60 log squaring steps, the multiply states StMul1 and
// StMul2, 20 square root steps, 30 CORDIC steps, and the product and
// rounding states. A uniform u1 of zero skips the second log and multiplies.
// The back end takes a new pair only after its sample has been taken; the
// front end can run ahead by a two-entry queue.
// Reset sets the seed and the LCG state to 1 and empties the queue.
// When the receiver stalls, the sample waits in the output register, the
// queue fills and s_axis_tready falls until room opens up.
module gaussian_noise_generator import gng_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [0] restart, [7:1] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [15:0] sample
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  `include "gaussian_noise_generator_assert.svh"

  logic [31:0] seed_q;
  q_wr_t       q_wr;
  q_rd_t       q_rd;
  logic        q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seed_q <= 32'd1;
    else if (cfg_valid) seed_q <= cfg_data;
  end

  gng_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .restart_i   (s_axis_tdata[0]),
    .seed_i      (seed_q),
    .q_full_i    (q_rd.full),
    .q_wr_o      (q_wr)
  );

  gng_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .pop_i  (q_pop),
    .rd_o   (q_rd)
  );

  gng_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_rd_i      (q_rd),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sample_o    (m_axis_tdata)
  );

  `GNG_ASSERT(a_no_push_full, !(q_wr.valid && q_rd.full), "push into full queue")
  `GNG_ASSERT(a_no_pop_empty, !(q_pop && q_rd.empty), "pop from empty queue")
  `GNG_ASSERT_NEXT(a_out_clears, m_axis_tvalid && m_axis_tready, !m_axis_tvalid, "repeat")
endmodule

FILE: rtl/gng_front.sv
// Front end: takes requests, steps the LCG twice and queues the two uniforms.
`timescale 1ns / 1ps
module gng_front import gng_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic        restart_i,
  input  logic [31:0] seed_i,
  input  logic        q_full_i,
  output q_wr_t       q_wr_o
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StOne  = 2'd1;
  localparam logic [1:0] StTwo  = 2'd2;
  localparam logic [1:0] StPush = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [31:0] lcg_q, lcg_d;
  logic [15:0] a_q, a_d;
  logic [15:0] b_q, b_d;
  logic [31:0] lcg_nxt;

  assign lcg_nxt     = lcg_q * LcgMul + LcgAdd;
  assign req_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    lcg_d   = lcg_q;
    a_d     = a_q;
    b_d     = b_q;
    q_wr_o  = '{valid: 1'b0, a: a_q, b: b_q};
    case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          if (restart_i) lcg_d = seed_i;
          state_d = StOne;
        end
      end
      StOne: begin
        lcg_d   = lcg_nxt;
        a_d     = lcg_nxt[23:8];
        state_d = StTwo;
      end
      StTwo: begin
        lcg_d   = lcg_nxt;
        b_d     = lcg_nxt[23:8];
        state_d = StPush;
      end
      StPush: begin
        if (!q_full_i) begin
          q_wr_o.valid = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      lcg_q   <= 32'd1;
    end else begin
      state_q <= state_d;
      lcg_q   <= lcg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end
endmodule

FILE: rtl/gng_queue.sv
// Short queue of uniform pairs between the front and back ends.
`timescale 1ns / 1ps
module gng_queue import gng_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  q_wr_t wr_i,
  input  logic  pop_i,
  output q_rd_t rd_o
);
  logic [31:0]      mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QPtrW:0]   cnt_q;
  logic             push, pop;

  assign rd_o.full  = (cnt_q == (QPtrW+1)'(QDepth));
  assign rd_o.empty = (cnt_q == '0);
  assign rd_o.a     = mem_q[rptr_q][31:16];
  assign rd_o.b     = mem_q[rptr_q][15:0];
  assign push       = wr_i.valid && !rd_o.full;
  assign pop        = pop_i && !rd_o.empty;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= {wr_i.a, wr_i.b};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop)  rptr_q <= rptr_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end
endmodule

FILE: rtl/gng_back.sv
// Back end: log, square root, CORDIC cosine and rounding, one step per cycle.
`timescale 1ns / 1ps
module gng_back import gng_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_rd_t       q_rd_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] sample_o
);
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StLogK = 4'd1;
  localparam logic [3:0] StLogA = 4'd2;
  localparam logic [3:0] StMul1 = 4'd3;
  localparam logic [3:0] StMul2 = 4'd4;
  localparam logic [3:0] StSqrt = 4'd5;
  localparam logic [3:0] StCord = 4'd6;
  localparam logic [3:0] StProd = 4'd7;
  localparam logic [3:0] StRnd  = 4'd8;
  localparam logic [3:0] StOut  = 4'd9;

  logic [3:0]         state_q;
  logic [4:0]         cnt_q;
  logic [15:0]        a_q, b_q;
  logic [3:0]         na_q;
  logic [30:0]        m_q;
  logic [29:0]        frac_q;
  logic [33:0]        lk_q, l_q;
  logic [45:0]        p_q;
  logic [39:0]        v_q, res_q, bit_q;
  logic signed [33:0] x_q, y_q;
  logic signed [32:0] z_q;
  logic               flip_q;
  logic signed [54:0] prod_q;
  logic [15:0]        sample_q;
  logic               valid_q;

  // Log step: square the mantissa and pull out one fraction bit.
  logic [61:0] sq;
  logic [31:0] sq_sh;
  logic        lbit;
  logic [30:0] m_nxt;
  logic [29:0] frac_nxt;
  assign sq       = 62'(m_q) * 62'(m_q);
  assign sq_sh    = sq[61:30];
  assign lbit     = sq_sh[31];
  assign m_nxt    = lbit ? sq_sh[31:1] : sq_sh[30:0];
  assign frac_nxt = {frac_q[28:0], lbit};

  logic [3:0]  na;
  logic [30:0] ma;
  assign na = lead_pos(a_q);
  assign ma = 31'(({15'd0, a_q} << (5'd30 - {1'b0, na})));

  logic [63:0] mul_hi, r2_sum;
  assign mul_hi = 64'(l_q[33:17]) * 64'(TwoLn2Q28);
  assign r2_sum = 64'(p_q) + (mul_hi << 17) + 64'(33554432);

  // Square root step.
  logic [39:0] trial;
  assign trial = res_q + bit_q;

  // CORDIC step.
  logic signed [33:0] xs, ys;
  logic signed [32:0] ang;
  assign xs  = x_q >>> cnt_q;
  assign ys  = y_q >>> cnt_q;
  assign ang = signed'({1'b0, atan_turn(cnt_q)});

  // Phase fold into [-1/4, 1/4) turn.
  logic [31:0] ph, ph_t, ph_f;
  logic        flip;
  assign ph   = {b_q, b_q};
  assign ph_t = ph + 32'h40000000;
  assign flip = ph_t[31];
  assign ph_f = flip ? (ph ^ 32'h80000000) : ph;

  // Round half away from zero and saturate.
  logic        neg;
  logic [54:0] mag;
  logic [54:0] mag_r;
  logic [15:0] res_sat;
  assign neg   = prod_q[54];
  assign mag   = neg ? 55'(-prod_q) : 55'(prod_q);
  assign mag_r = (mag + (55'd1 << (45 - FracBits))) >> (46 - FracBits);
  always_comb begin
    if (neg) res_sat = (mag_r > 55'd32768) ? 16'h8000 : 16'(-mag_r);
    else     res_sat = (mag_r > 55'd32767) ? 16'h7FFF : mag_r[15:0];
  end

  logic signed [33:0] c_val;
  assign c_val = flip_q ? -x_q : x_q;

  assign q_pop_o     = (state_q == StIdle) && !q_rd_i.empty;
  assign out_valid_o = valid_q;
  assign sample_o    = sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (!q_rd_i.empty) begin
            state_q <= StLogK;
            cnt_q   <= '0;
          end
        end
        StLogK: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'(LogSteps - 1)) begin
            cnt_q   <= '0;
            state_q <= (a_q == '0) ? StSqrt : StLogA;
          end
        end
        StLogA: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'(LogSteps - 1)) state_q <= StMul1;
        end
        StMul1: state_q <= StMul2;
        StMul2: begin
          state_q <= StSqrt;
          cnt_q   <= '0;
        end
        StSqrt: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'(SqrtSteps - 1)) begin
            cnt_q   <= '0;
            state_q <= StCord;
          end
        end
        StCord: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'(CordicSteps - 1)) state_q <= StProd;
        end
        StProd: state_q <= StRnd;
        StRnd: begin
          valid_q <= 1'b1;
          state_q <= StOut;
        end
        StOut: begin
          if (out_ready_i) begin
            valid_q <= 1'b0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        a_q    <= q_rd_i.a;
        b_q    <= q_rd_i.b;
        m_q    <= 31'(32'd65535 << 15);
        frac_q <= '0;
      end
      StLogK: begin
        m_q    <= m_nxt;
        frac_q <= frac_nxt;
        if (cnt_q == 5'(LogSteps - 1)) begin
          lk_q   <= {4'd15, frac_nxt};
          m_q    <= ma;
          na_q   <= na;
          frac_q <= '0;
          v_q    <= R2AtZero;
          res_q  <= '0;
          bit_q  <= 40'd1 << 38;
        end
      end
      StLogA: begin
        m_q    <= m_nxt;
        frac_q <= frac_nxt;
        if (cnt_q == 5'(LogSteps - 1)) l_q <= lk_q - {na_q, frac_nxt};
      end
      StMul1: p_q <= 46'(l_q[16:0]) * 46'(TwoLn2Q28);
      StMul2: begin
        v_q   <= {2'b00, r2_sum[63:26]};
        res_q <= '0;
        bit_q <= 40'd1 << 38;
      end
      StSqrt: begin
        if (v_q >= trial) begin
          v_q   <= v_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (cnt_q == 5'(SqrtSteps - 1)) begin
          x_q    <= signed'(CordicK);
          y_q    <= '0;
          z_q    <= signed'({ph_f[31], ph_f});
          flip_q <= flip;
        end
      end
      StCord: begin
        if (!z_q[32]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - ang;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + ang;
        end
      end
      StProd: prod_q <= signed'({1'b0, res_q[19:0]}) * 55'(c_val);
      StRnd:  sample_q <= res_sat;
      default: ;
    endcase
  end
endmodule
